// ----- design/pdq_pkg.sv -----
// ----------------------------------------------------------------------------
// pdq_pkg
// Shared types and constants for the point dequantizer.
// ----------------------------------------------------------------------------
package pdq_pkg;

  localparam int unsigned CoordW = 16;
  localparam int unsigned MagW   = 16;
  localparam int unsigned ProdW  = 40;
  localparam int unsigned FloatW = 32;
  localparam int unsigned ColW   = 24;

  // Mantissa of 0.1f (0x3DCCCCCD) with the hidden bit.
  localparam logic [23:0] ScaleMant = 24'hCCCCCD;
  // Product is prod * 2^-27; exponent field = msb index + 127 - 27.
  localparam logic [7:0]  ExpAdj    = 8'd100;

  typedef struct packed {
    logic signed [CoordW-1:0] coord_x;
    logic signed [CoordW-1:0] coord_y;
    logic signed [CoordW-1:0] coord_z;
    logic [15:0]              colour_packed;
  } point_in_t;

  typedef struct packed {
    logic [FloatW-1:0] x_float;
    logic [FloatW-1:0] y_float;
    logic [FloatW-1:0] z_float;
    logic [ColW-1:0]   colour_word;
  } point_out_t;

  function automatic logic [ColW-1:0] expand_colour(input logic [15:0] w);
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r = {w[15:10], 2'b00};
    g = {w[9:4], 2'b00};
    b = {w[3:0], 4'b0000};
    return {r, g, b};
  endfunction

endpackage

// ----- design/pdq_if.sv -----
// ----------------------------------------------------------------------------
// pdq_if
// Valid/ready channel carrying one point or one result per beat.
// ----------------------------------------------------------------------------
interface pdq_in_if;
  import pdq_pkg::*;
  logic      valid;
  logic      ready;
  point_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface pdq_out_if;
  import pdq_pkg::*;
  logic       valid;
  logic       ready;
  point_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- design/pdq_scale.sv -----
// ----------------------------------------------------------------------------
// pdq_scale
// Three-stage int16 to float32 conversion times 0.1f, round to nearest even.
// Stage 1: magnitude and sign. Stage 2: multiply. Stage 3: normalize, round.
// ----------------------------------------------------------------------------
module pdq_scale (
  input  logic                          clk,
  input  logic                          en,
  input  logic [pdq_pkg::CoordW-1:0]    coord,
  output logic [pdq_pkg::FloatW-1:0]    result
);
  import pdq_pkg::*;

  logic [MagW:0]    mag;
  logic             sgn1;
  logic             zero1;
  logic [ProdW-1:0] prod;
  logic             sgn2;
  logic             zero2;
  logic [5:0]       msb;
  logic [ProdW-1:0] norm;
  logic [23:0]      mant;
  logic             rbit;
  logic             sticky;
  logic [24:0]      rnd;
  logic [7:0]       expo;
  logic [FloatW-1:0] result_next;

  // Stage 1: take magnitude; even -32768 gives a magnitude that fits in 16 bits.
  always_ff @(posedge clk) begin
    if (en) begin
      mag   <= coord[CoordW-1] ? (17'h10000 - {1'b0, coord}) : {1'b0, coord};
      sgn1  <= coord[CoordW-1];
      zero1 <= (coord == '0);
    end
  end

  // Stage 2: 17 x 24 multiply.
  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= ProdW'({23'd0, mag} * {16'd0, ScaleMant});
      sgn2  <= sgn1;
      zero2 <= zero1;
    end
  end

  // Stage 3: a nonzero product is at least 2^23, so the msb lies in 23..38.
  always_comb begin
    msb = 6'd23;
    for (int i = 24; i < ProdW; i++) begin
      if (prod[i]) msb = 6'(i);
    end
    norm   = prod << (6'(ProdW - 1) - msb);
    mant   = norm[ProdW-1 -: 24];
    rbit   = norm[ProdW-25];
    sticky = |norm[ProdW-26:0];
    rnd    = {1'b0, mant} + 25'(rbit & (sticky | mant[0]));
    expo   = 8'(msb) + ExpAdj;
    if (rnd[24]) begin
      expo = expo + 8'd1;
      rnd  = rnd >> 1;
    end
    result_next = zero2 ? '0 : {sgn2, expo, rnd[22:0]};
  end

  always_ff @(posedge clk) begin
    if (en) result <= result_next;
  end
endmodule

// ----- design/point_dequantize_rgb664_unpack.sv -----
// ----------------------------------------------------------------------------
// point_dequantize_rgb664_unpack
// Point dequantizer: int16 xyz times 0.1f to float32, RGB 6-6-4 to 8-8-8.
// ----------------------------------------------------------------------------
// Takes one point per beat and returns one result per beat, one point per
// cycle sustained while the output is not stalled. The stages are magnitude,
// a 17x24 multiply, then normalize and round, in order. The whole pipeline
// advances together whenever its last stage is empty or being drained, so a
// stall on the output holds every stage and nothing is dropped or repeated.
// Colour expansion rides along in the same stages. No state beyond the
// pipeline; reset only clears the valid bits.
module point_dequantize_rgb664_unpack (
  input logic clk,
  input logic rst,
  pdq_in_if.sink   in_ch,
  pdq_out_if.source out_ch
);
  import pdq_pkg::*;

  localparam int unsigned Depth = 3;

  logic [Depth-1:0] vld;
  logic             advance;
  logic [ColW-1:0]  colour [Depth];

  // Move the pipeline whenever the output stage can take a new beat.
  assign advance  = !vld[Depth-1] || out_ch.ready;
  assign in_ch.ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[Depth-2:0], in_ch.valid};
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      colour[0] <= expand_colour(in_ch.data.colour_packed);
      for (int i = 1; i < Depth; i++) colour[i] <= colour[i-1];
    end
  end

  pdq_scale u_x (.clk(clk), .en(advance), .coord(in_ch.data.coord_x),
                 .result(out_ch.data.x_float));
  pdq_scale u_y (.clk(clk), .en(advance), .coord(in_ch.data.coord_y),
                 .result(out_ch.data.y_float));
  pdq_scale u_z (.clk(clk), .en(advance), .coord(in_ch.data.coord_z),
                 .result(out_ch.data.z_float));

  assign out_ch.data.colour_word = colour[Depth-1];
  assign out_ch.valid = vld[Depth-1];

`ifndef NO_ASSERTIONS
  // A held result stays valid until it is taken.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid)
    else $error("result dropped while stalled");
  // An accepted point reaches the output stage once the pipeline has advanced it through every stage.
  a_lat: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready ##1 advance ##1 advance |=> vld[Depth-1] || !advance)
    else $error("point lost in pipeline");
  // Input is refused only when the output is stalled.
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> out_ch.valid && !out_ch.ready)
    else $error("input stalled without output backpressure");
`endif
endmodule

// ----- verif/point_dequantize_rgb664_unpack_test.sv -----
// ----------------------------------------------------------------------------
// point_dequantize_rgb664_unpack_test
// Drives points through the dequantizer with random gaps and stalls, predicts
// each result with an integer model of the 0.1f multiply and the 6-6-4 colour
// expansion, and checks every output beat against the oldest prediction.
// ----------------------------------------------------------------------------
module point_dequantize_rgb664_unpack_test;
  import pdq_pkg::*;

  logic clk = 1'b0;
  logic rst;

  pdq_in_if  in_ch ();
  pdq_out_if out_ch ();

  point_dequantize_rgb664_unpack uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  // Predicted results, oldest first; the checker walks them by index.
  point_out_t expected_points[$];
  int         checked = 0;
  int         mismatches = 0;
  int         src_idle_pct;
  int         snk_idle_pct;
  int         hold_off_requests = 0;
  int         hold_off_seen;
  int         hold_off_cycles;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scale one coordinate by 0.1f with round to nearest even, in integers.
  function automatic logic [31:0] scaled_coord(input logic signed [15:0] c);
    logic [16:0] mag;
    logic [63:0] prod;
    logic [63:0] mant;
    logic [63:0] rem;
    logic [63:0] half;
    int          msb;
    int          sh;
    logic        neg;
    if (c == 16'sd0) return 32'h0;
    neg  = c[15];
    mag  = neg ? (17'h10000 - {1'b0, c}) : {1'b0, c};
    prod = 64'(mag) * 64'(ScaleMant);
    msb  = 0;
    for (int i = 0; i < 64; i++) if (prod[i]) msb = i;
    sh = msb - 23;
    if (sh > 0) begin
      rem  = prod & ((64'd1 << sh) - 64'd1);
      half = 64'd1 << (sh - 1);
      mant = prod >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == (64'd1 << 24)) begin
        mant = mant >> 1;
        msb++;
      end
    end else begin
      mant = prod << (-sh);
    end
    return {neg, 8'(msb + 100), mant[22:0]};
  endfunction

  function automatic point_out_t dequantized_point(input point_in_t p);
    point_out_t r;
    r.x_float     = scaled_coord(p.coord_x);
    r.y_float     = scaled_coord(p.coord_y);
    r.z_float     = scaled_coord(p.coord_z);
    r.colour_word = {p.colour_packed[15:10], 2'b00, p.colour_packed[9:4], 2'b00,
                     p.colour_packed[3:0], 4'b0000};
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h want %h", what, got, want);
    mismatches++;
  endtask

  // Send one point: hold valid until the beat is taken, idle at random.
  task automatic send_point(input point_in_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= p;
    expected_points = {expected_points, dequantized_point(p)};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic point_in_t random_point();
    point_in_t p;
    p = {$urandom, $urandom};
    // Bias some coordinates toward small magnitudes and extremes.
    case ($urandom_range(3))
      0: p.coord_x = 16'($signed($urandom_range(20)) - 10);
      1: p.coord_y = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
      default: ;
    endcase
    return p;
  endfunction

  // Ready side: random stalls, plus a long hold-off on request.
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready    <= 1'b0;
      hold_off_seen   <= 0;
      hold_off_cycles <= 0;
    end else if (hold_off_seen != hold_off_requests) begin
      out_ch.ready    <= 1'b0;
      hold_off_seen   <= hold_off_requests;
      hold_off_cycles <= 60;
    end else if (hold_off_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_off_cycles <= hold_off_cycles - 1;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Check each output beat against the oldest unchecked prediction.
  always @(posedge clk) begin
    point_out_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (checked >= expected_points.size()) begin
        report_mismatch("unexpected beat", out_ch.data.x_float, 32'h0);
      end else begin
        want = expected_points[checked];
        checked <= checked + 1;
        if (out_ch.data.x_float !== want.x_float)
          report_mismatch("x_float", out_ch.data.x_float, want.x_float);
        if (out_ch.data.y_float !== want.y_float)
          report_mismatch("y_float", out_ch.data.y_float, want.y_float);
        if (out_ch.data.z_float !== want.z_float)
          report_mismatch("z_float", out_ch.data.z_float, want.z_float);
        if (out_ch.data.colour_word !== want.colour_word)
          report_mismatch("colour_word", 32'(out_ch.data.colour_word),
                          32'(want.colour_word));
      end
    end
  end

  task automatic test_directed();
    logic signed [15:0] coords[8] = '{16'sd0, 16'sd1, -16'sd1, 16'sd10, -16'sd10,
                                      16'sh7FFF, 16'sh8000, 16'sd3};
    logic [15:0] colours[8] = '{16'h0000, 16'hFFFF, 16'hFC00, 16'h03F0,
                                16'h000F, 16'hAAAA, 16'h5555, 16'h8421};
    for (int i = 0; i < 8; i++)
      send_point('{coords[i], coords[(i + 3) % 8], coords[(i + 5) % 8], colours[i]});
  endtask

  task automatic test_random(input int count);
    for (int i = 0; i < count; i++) begin
      // Leave a long stretch with no idling on either side.
      if (i == count / 2) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      if (i == count / 2 + 200) begin
        src_idle_pct = 26;
        snk_idle_pct = 26;
      end
      send_point(random_point());
    end
  endtask

  // Stall the output long enough to fill the pipeline and back up the input.
  task automatic test_backpressure();
    hold_off_requests++;
    src_idle_pct = 0;
    for (int i = 0; i < 30; i++) send_point(random_point());
    src_idle_pct = 26;
  endtask

  initial begin
    rst             = 1'b1;
    in_ch.valid     = 1'b0;
    in_ch.data      = '0;
    src_idle_pct    = 26;
    snk_idle_pct    = 26;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random(1400);
    in_ch.valid <= 1'b0;
    // Drain, then keep watching the pipeline for stray beats.
    while (checked != expected_points.size()) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0 && checked == expected_points.size()) begin
      $display("[point_dequantize_rgb664_unpack] OK");
    end else begin
      $display("[point_dequantize_rgb664_unpack] ERROR");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("[point_dequantize_rgb664_unpack] ERROR");
    $finish;
  end

endmodule

// ----- sim.f -----
design/pdq_pkg.sv
design/pdq_if.sv
design/pdq_scale.sv
design/point_dequantize_rgb664_unpack.sv
verif/point_dequantize_rgb664_unpack_test.sv
